// ===== hdl/ppt_pkg.sv =====
// Shared types and constants for the projective point transform.
`default_nettype none
package ppt_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned NumW     = 57;
  localparam int unsigned DenW     = 61;
  localparam int unsigned FeedW    = 12;
  localparam int unsigned QuoW     = 25;
  localparam int unsigned NumCells = QuoW;

  localparam logic [2:0] RegXLinear = 3'd0;
  localparam logic [2:0] RegXOffset = 3'd1;
  localparam logic [2:0] RegYLinear = 3'd2;
  localparam logic [2:0] RegYOffset = 3'd3;
  localparam logic [2:0] RegWLinear = 3'd4;
  localparam logic [2:0] RegWOffset = 3'd5;

  localparam logic [CoordW-1:0] OutMax = 24'h7FFFFF;
  localparam logic [CoordW-1:0] OutMin = 24'h800000;

  typedef struct packed {
    logic [63:0] x_linear;
    logic [47:0] x_offset;
    logic [63:0] y_linear;
    logic [47:0] y_offset;
    logic [63:0] w_linear;
    logic [47:0] w_offset;
  } cfg_t;

  typedef struct packed {
    logic [DenW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [FeedW-1:0] feed;
    logic [QuoW-1:0]  quo;
  } div_t;

  typedef struct packed {
    logic valid;
    logic wz;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } side_t;

endpackage
`default_nettype wire

// ===== hdl/ppt_div_cell.sv =====
// One restoring division step: produces one quotient bit per item.
`default_nettype none
module ppt_div_cell import ppt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic en_i,
  input  div_t      div_i,
  output div_t      div_o
);

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            take;
  div_t            div_d;
  div_t            div_q;

  always_comb begin
    trial = {div_i.rem, div_i.feed[FeedW-1]};
    diff  = trial - {1'b0, div_i.den};
    take  = (trial >= {1'b0, div_i.den});
    div_d.rem  = take ? diff[DenW-1:0] : trial[DenW-1:0];
    div_d.den  = div_i.den;
    div_d.feed = {div_i.feed[FeedW-2:0], 1'b0};
    div_d.quo  = {div_i.quo[QuoW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule
`default_nettype wire

// ===== hdl/ppt_cfg_regs.sv =====
// Matrix coefficient registers with their write port.
`default_nettype none
module ppt_cfg_regs import ppt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_linear <= 64'd16777216;
      cfg_q.x_offset <= 48'd0;
      cfg_q.y_linear <= 64'd72057594037927936;
      cfg_q.y_offset <= 48'd0;
      cfg_q.w_linear <= 64'd0;
      cfg_q.w_offset <= 48'd16777216;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegXLinear: cfg_q.x_linear <= cfg_data_i;
        RegXOffset: cfg_q.x_offset <= cfg_data_i[47:0];
        RegYLinear: cfg_q.y_linear <= cfg_data_i;
        RegYOffset: cfg_q.y_offset <= cfg_data_i[47:0];
        RegWLinear: cfg_q.w_linear <= cfg_data_i;
        RegWOffset: cfg_q.w_offset <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule
`default_nettype wire

// ===== hdl/projective_point_transform.sv =====
// Top level of the projective point transform pipeline.
//
// Each input word carries a point (point_x_i, point_y_i) in signed Q16.8. It is
// accepted when in_valid_i is high and in_stall_o is low. One result word
// (mapped_x_o, mapped_y_o, w_zero_o, clipped_o) leaves for each point, in
// order, when out_valid_o is high and out_stall_i is low.
// The matrix is written through the configuration port (cfg_valid_i,
// cfg_ready_o, cfg_index_i, cfg_data_i); the port is always ready, and writes
// to an index above five are dropped. Write it only while the pipe is empty.
// Throughput is one point per cycle while the receiver does not stall. From
// acceptance to out_valid_o a point passes one multiply stage, one sum
// stage, one magnitude stage, one overflow check stage, 25 division cells
// (one quotient bit each) and the rounding output register.
// When the receiver stalls with a word waiting, the whole pipe holds and
// in_stall_o rises in the same cycle; bubbles move on freely otherwise.
// Reset clears all valid bits and loads the identity matrix.
`default_nettype none
module projective_point_transform import ppt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CoordW-1:0] point_x_i,
  input  wire logic [CoordW-1:0] point_y_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CoordW-1:0]      mapped_x_o,
  output logic [CoordW-1:0]      mapped_y_o,
  output logic                   w_zero_o,
  output logic                   clipped_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [63:0]       cfg_data_i
);

  cfg_t cfg;
  logic en;

  ppt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The pipe moves whenever the output register is free or being drained.
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: the six coefficient products.
  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [23:0] px, py;
  logic signed [55:0] ax_d, by_d, dx_d, ey_d, gx_d, hy_d;
  logic signed [55:0] ax_q, by_q, dx_q, ey_q, gx_q, hy_q;

  assign px   = $signed(point_x_i);
  assign py   = $signed(point_y_i);
  assign ax_d = $signed(cfg.x_linear[31:0])  * px;
  assign by_d = $signed(cfg.x_linear[63:32]) * py;
  assign dx_d = $signed(cfg.y_linear[31:0])  * px;
  assign ey_d = $signed(cfg.y_linear[63:32]) * py;
  assign gx_d = $signed(cfg.w_linear[31:0])  * px;
  assign hy_d = $signed(cfg.w_linear[63:32]) * py;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax_d;
      by_q <= by_d;
      dx_q <= dx_d;
      ey_q <= ey_d;
      gx_q <= gx_d;
      hy_q <= hy_d;
    end
  end

  // Stage 2: numerators at scale 2^32, w at scale 2^36.
  logic signed [63:0] nx_d, ny_d, w_d, nx_q, ny_q, w_q;

  assign nx_d = 64'(ax_q) + 64'(by_q)
              + $signed({{8{cfg.x_offset[47]}}, cfg.x_offset, 8'b0});
  assign ny_d = 64'(dx_q) + 64'(ey_q)
              + $signed({{8{cfg.y_offset[47]}}, cfg.y_offset, 8'b0});
  assign w_d  = 64'(gx_q) + 64'(hy_q)
              + $signed({{4{cfg.w_offset[47]}}, cfg.w_offset, 12'b0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      w_q  <= w_d;
    end
  end

  // Stage 3: magnitudes and signs; a zero w is replaced by one.
  logic [63:0]      nx_neg, ny_neg, w_neg;
  logic [NumW-1:0]  nmx_d, nmy_d, nmx_q, nmy_q;
  logic [DenW-1:0]  dm_d, dm_q;
  logic             wz_d, wz3_q, negx_d, negy_d, negx3_q, negy3_q;

  always_comb begin
    nx_neg = -nx_q;
    ny_neg = -ny_q;
    w_neg  = -w_q;
    nmx_d  = nx_q[63] ? nx_neg[NumW-1:0] : nx_q[NumW-1:0];
    nmy_d  = ny_q[63] ? ny_neg[NumW-1:0] : ny_q[NumW-1:0];
    wz_d   = (w_q == 64'sd0);
    if (wz_d) begin
      dm_d = DenW'(64'd1 << 36);
    end else begin
      dm_d = w_q[63] ? w_neg[DenW-1:0] : w_q[DenW-1:0];
    end
    negx_d = nx_q[63] ^ w_q[63];
    negy_d = ny_q[63] ^ w_q[63];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nmx_q   <= nmx_d;
      nmy_q   <= nmy_d;
      dm_q    <= dm_d;
      wz3_q   <= wz_d;
      negx3_q <= negx_d;
      negy3_q <= negy_d;
    end
  end

  // Stage 4: quotients of 4096 or more saturate; load the division rows.
  localparam int unsigned CmpW = DenW + FeedW;
  div_t  divx_d, divy_d, divx4_q, divy4_q;
  side_t side_d, side4_q;

  always_comb begin
    divx_d.rem  = DenW'(nmx_q[NumW-1:FeedW]);
    divx_d.den  = dm_q;
    divx_d.feed = nmx_q[FeedW-1:0];
    divx_d.quo  = '0;
    divy_d.rem  = DenW'(nmy_q[NumW-1:FeedW]);
    divy_d.den  = dm_q;
    divy_d.feed = nmy_q[FeedW-1:0];
    divy_d.quo  = '0;
    side_d.valid = v3_q;
    side_d.wz    = wz3_q;
    side_d.neg_x = negx3_q;
    side_d.neg_y = negy3_q;
    side_d.sat_x = (CmpW'(nmx_q) >= {dm_q, {FeedW{1'b0}}});
    side_d.sat_y = (CmpW'(nmy_q) >= {dm_q, {FeedW{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      divx4_q <= divx_d;
      divy4_q <= divy_d;
      side4_q <= side_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Division rows: each cell settles one quotient bit and passes its
  // remainder on. Flags ride alongside in a matching shift line.
  div_t  chain_x [NumCells+1];
  div_t  chain_y [NumCells+1];
  side_t side_q  [NumCells];
  side_t side_in [NumCells];
  logic  side_v_q [NumCells];

  assign chain_x[0] = divx4_q;
  assign chain_y[0] = divy4_q;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    ppt_div_cell u_cx (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (chain_x[k]),
      .div_o (chain_x[k+1])
    );
    ppt_div_cell u_cy (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i (chain_y[k]),
      .div_o (chain_y[k+1])
    );
    if (k == 0) begin : g_first
      assign side_in[k] = '{valid: v4_q, wz: side4_q.wz, neg_x: side4_q.neg_x,
                            neg_y: side4_q.neg_y, sat_x: side4_q.sat_x,
                            sat_y: side4_q.sat_y};
    end else begin : g_next
      assign side_in[k] = '{valid: side_v_q[k-1], wz: side_q[k-1].wz,
                            neg_x: side_q[k-1].neg_x, neg_y: side_q[k-1].neg_y,
                            sat_x: side_q[k-1].sat_x, sat_y: side_q[k-1].sat_y};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_in[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_v_q[k] <= 1'b0;
      end else if (en) begin
        side_v_q[k] <= side_in[k].valid;
      end
    end
  end

  // Output stage: round half away from zero, then saturate. The rounding
  // add keeps its carry, since a quotient just below 4096 rounds up to 2^24.
  logic [QuoW-1:0]   qx, qy, mx, my;
  logic [QuoW:0]     qx1, qy1;
  logic [CoordW-1:0] rx_d, ry_d, rx_q, ry_q;
  logic              clipx, clipy, wz_q, clip_q;
  side_t             last;

  assign last = side_q[NumCells-1];
  assign qx   = chain_x[NumCells].quo;
  assign qy   = chain_y[NumCells].quo;
  assign qx1  = {1'b0, qx} + {{QuoW{1'b0}}, 1'b1};
  assign qy1  = {1'b0, qy} + {{QuoW{1'b0}}, 1'b1};
  assign mx   = qx1[QuoW:1];
  assign my   = qy1[QuoW:1];

  always_comb begin
    if (last.neg_x) begin
      clipx = last.sat_x || (mx > QuoW'(24'h800000));
      rx_d  = clipx ? OutMin : (~mx[CoordW-1:0] + CoordW'(1));
    end else begin
      clipx = last.sat_x || (mx > QuoW'(OutMax));
      rx_d  = clipx ? OutMax : mx[CoordW-1:0];
    end
    if (last.neg_y) begin
      clipy = last.sat_y || (my > QuoW'(24'h800000));
      ry_d  = clipy ? OutMin : (~my[CoordW-1:0] + CoordW'(1));
    end else begin
      clipy = last.sat_y || (my > QuoW'(OutMax));
      ry_d  = clipy ? OutMax : my[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      wz_q   <= last.wz;
      clip_q <= clipx || clipy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_v_q[NumCells-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign mapped_x_o  = rx_q;
  assign mapped_y_o  = ry_q;
  assign w_zero_o    = wz_q;
  assign clipped_o   = clip_q;

`ifndef SYNTH
  // A remainder entering the division rows must stay below the divisor
  // unless the overflow check has already claimed that lane.
  a_rem_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !side4_q.sat_x) |-> (divx4_q.rem < divx4_q.den))
    else $error("x remainder not below divisor at row entry");
  a_rem_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !side4_q.sat_y) |-> (divy4_q.rem < divy4_q.den))
    else $error("y remainder not below divisor at row entry");
  // Back pressure is raised only while a finished word waits.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting output word");
`endif

endmodule
`default_nettype wire
